FILE: rtl/oach_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oach_pkg: shared constants and types of the angular convex hull
// Widths, datapath command and status words, shared by controller and datapath.
// ----------------------------------------------------------------------------
package oach_pkg;

   localparam int CAPACITY    = 1024;
   localparam int COORD_BITS  = 21;
   localparam int CENTER_W    = COORD_BITS + 1;     // doubled center
   localparam int REL_W       = COORD_BITS + 2;     // doubled relative coordinate
   localparam int DIFF_W      = REL_W + 1;          // difference of two coordinates
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int ENTRY_W     = 2 * REL_W;
   localparam int MIN_CLEANUP = 3;                  // no neighbor erase at or below this

   typedef enum logic [1:0] {SLOT_HOLD, SLOT_MEM, SLOT_PT} slot_src_type;

   typedef enum logic [2:0] {
      RD_POS, RD_PREV, RD_PREV2, RD_NEXT, RD_NEXT2, RD_IDX_DN, RD_IDX_UP
   } rd_sel_type;

   typedef enum logic [1:0] {WR_NONE, WR_POINT, WR_SHIFT} wr_sel_type;

   typedef enum logic [1:0] {
      MUL_ANGLE, MUL_DIST_PT, MUL_DIST_TAB, MUL_REFLEX
   } mul_sel_type;

   typedef enum logic [2:0] {
      POS_HOLD, POS_CLEAR, POS_INC, POS_BACK_ERASE, POS_FWD_ERASE
   } pos_op_type;

   typedef enum logic [2:0] {
      IDX_HOLD, IDX_COUNT, IDX_PREV, IDX_NEXT, IDX_POS, IDX_DEC, IDX_INC
   } idx_op_type;

   typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_type;

   typedef struct packed {
      logic         load_point;
      rd_sel_type   rd_sel;
      wr_sel_type   wr_sel;
      mul_sel_type  mul_sel;
      slot_src_type ld_a;
      slot_src_type ld_b;
      slot_src_type ld_c;
      pos_op_type   pos_op;
      idx_op_type   idx_op;
      cnt_op_type   cnt_op;
      logic         save_dist;
   } cmd_type;

   typedef struct packed {
      logic pos_end;
      logic ang_less;
      logic ang_eq;
      logic farther;
      logic full;
      logic small_hull;
      logic shift_more;
      logic erase_more;
      logic reflex;
   } stat_type;

endpackage
`default_nettype wire

FILE: rtl/online_angular_convex_hull.sv
`default_nettype none
// ----------------------------------------------------------------------------
// online_angular_convex_hull: incremental convex hull in angular order
// One point per command; the hull is kept sorted by angle around a center.
// ----------------------------------------------------------------------------
//  channel   ports                                    handshake
//  command   start, busy, req_point_x, req_point_y    taken when start & !busy
//  result    rsp_strobe, rsp_hull_count, rsp_overflow one cycle, no back-pressure
//  config    psel, penable, pwrite, paddr, pwdata,    APB, pready tied high
//            prdata, pready                           0: center_x_sum 4: center_y_sum
//
//  The update walks the table one entry at a time: the angle search passes
//  entries in order, inserting or erasing a point moves each later entry,
//  and each reflex test first reads its neighbors from the table.
//  The table holds up to 1024 entries.
//  Reset (synchronous) empties the hull and clears the center; table contents
//  are not cleared, only entries below the hull count are ever read.
//  The result word is shown for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module online_angular_convex_hull (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic signed [oach_pkg::COORD_BITS-1:0] req_point_x,
   input  wire logic signed [oach_pkg::COORD_BITS-1:0] req_point_y,
   output logic                                       rsp_strobe,
   output logic [oach_pkg::CNT_W-1:0]                 rsp_hull_count,
   output logic                                       rsp_overflow,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [2:0]                            paddr,
   input  wire logic [31:0]                           pwdata,
   output logic [31:0]                                prdata,
   output logic                                       pready
);
   import oach_pkg::*;

   localparam logic REG_CENTER_X = 1'b0;
   localparam logic REG_CENTER_Y = 1'b1;

   logic signed [CENTER_W-1:0] cx_ff, cy_ff;
   logic                       wr_stb;
   cmd_type                    cmd;
   stat_type                   stat;

   // register write on the access phase
   assign wr_stb = psel & penable & pwrite & pready;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
      end else if (wr_stb) begin
         if (paddr[2] == REG_CENTER_X) cx_ff <= pwdata[CENTER_W-1:0];
         if (paddr[2] == REG_CENTER_Y) cy_ff <= pwdata[CENTER_W-1:0];
      end
   end

   // read back sign-extended
   assign prdata = (paddr[2] == REG_CENTER_Y) ? 32'(cy_ff) : 32'(cx_ff);

   oach_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .done     (rsp_strobe),
      .overflow (rsp_overflow),
      .cmd      (cmd),
      .stat     (stat)
   );

   oach_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .point_x  (req_point_x),
      .point_y  (req_point_y),
      .center_x (cx_ff),
      .center_y (cy_ff),
      .cmd      (cmd),
      .stat     (stat),
      .count    (rsp_hull_count)
   );

endmodule
`default_nettype wire

FILE: rtl/oach_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oach_ctrl: sequencer of the hull update
// Walks search, replace or insert, backward and forward clean-up, final test.
// ----------------------------------------------------------------------------
module oach_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   output logic                   done,
   output logic                   overflow,
   output oach_pkg::cmd_type      cmd,
   input  wire oach_pkg::stat_type stat
);
   import oach_pkg::*;

   typedef enum logic [4:0] {
      IDLE, SRCH, SRCH_LD, SRCH_MUL, SRCH_CMP,
      DIST_P, DIST_T, DIST_CMP,
      INS, SHIFT, SHIFT_WR,
      BACK, BACK_A, BACK_B, BACK_MUL, BACK_TEST,
      FWD, FWD_B, FWD_C, FWD_MUL, FWD_TEST,
      LAST, LAST_A, LAST_C, LAST_MUL, LAST_TEST,
      ERASE, ERASE_WR, DONE
   } state_type;

   typedef enum logic [1:0] {PH_BACK, PH_FWD, PH_LAST} phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      ovf_ff, ovf_in;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      ovf_in   = ovf_ff;
      cmd      = '{load_point: 1'b0, rd_sel: RD_POS, wr_sel: WR_NONE,
                   mul_sel: MUL_ANGLE, ld_a: SLOT_HOLD, ld_b: SLOT_HOLD,
                   ld_c: SLOT_HOLD, pos_op: POS_HOLD, idx_op: IDX_HOLD,
                   cnt_op: CNT_HOLD, save_dist: 1'b0};
      case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load_point = 1'b1;
               cmd.pos_op     = POS_CLEAR;
               ovf_in         = 1'b0;
               state_in       = SRCH;
            end
         end
         SRCH: begin
            if (stat.pos_end) begin
               state_in = INS;
            end else begin
               cmd.rd_sel = RD_POS;
               state_in   = SRCH_LD;
            end
         end
         SRCH_LD: begin
            cmd.ld_b = SLOT_MEM;
            state_in = SRCH_MUL;
         end
         SRCH_MUL: begin
            cmd.mul_sel = MUL_ANGLE;
            state_in    = SRCH_CMP;
         end
         SRCH_CMP: begin
            if (stat.ang_less) begin
               cmd.pos_op = POS_INC;
               state_in   = SRCH;
            end else if (stat.ang_eq) begin
               state_in = DIST_P;
            end else begin
               state_in = INS;
            end
         end
         DIST_P: begin
            cmd.mul_sel = MUL_DIST_PT;
            state_in    = DIST_T;
         end
         DIST_T: begin
            cmd.save_dist = 1'b1;
            cmd.mul_sel   = MUL_DIST_TAB;
            state_in      = DIST_CMP;
         end
         DIST_CMP: begin
            if (stat.farther) begin
               cmd.wr_sel = WR_POINT;
               state_in   = BACK;
            end else begin
               state_in = DONE;
            end
         end
         INS: begin
            if (stat.full) begin
               ovf_in   = 1'b1;
               state_in = DONE;
            end else begin
               cmd.idx_op = IDX_COUNT;
               state_in   = SHIFT;
            end
         end
         SHIFT: begin
            if (stat.shift_more) begin
               cmd.rd_sel = RD_IDX_DN;
               state_in   = SHIFT_WR;
            end else begin
               cmd.wr_sel = WR_POINT;
               cmd.cnt_op = CNT_INC;
               state_in   = BACK;
            end
         end
         SHIFT_WR: begin
            cmd.wr_sel = WR_SHIFT;
            cmd.idx_op = IDX_DEC;
            state_in   = SHIFT;
         end
         BACK: begin
            if (stat.small_hull) begin
               state_in = FWD;
            end else begin
               cmd.rd_sel = RD_PREV2;
               state_in   = BACK_A;
            end
         end
         BACK_A: begin
            cmd.ld_a   = SLOT_MEM;
            cmd.rd_sel = RD_PREV;
            state_in   = BACK_B;
         end
         BACK_B: begin
            cmd.ld_b = SLOT_MEM;
            cmd.ld_c = SLOT_PT;
            state_in = BACK_MUL;
         end
         BACK_MUL: begin
            cmd.mul_sel = MUL_REFLEX;
            state_in    = BACK_TEST;
         end
         BACK_TEST: begin
            if (stat.reflex) begin
               cmd.idx_op = IDX_PREV;
               cmd.pos_op = POS_BACK_ERASE;
               phase_in   = PH_BACK;
               state_in   = ERASE;
            end else begin
               state_in = FWD;
            end
         end
         FWD: begin
            if (stat.small_hull) begin
               state_in = LAST;
            end else begin
               cmd.ld_a   = SLOT_PT;
               cmd.rd_sel = RD_NEXT;
               state_in   = FWD_B;
            end
         end
         FWD_B: begin
            cmd.ld_b   = SLOT_MEM;
            cmd.rd_sel = RD_NEXT2;
            state_in   = FWD_C;
         end
         FWD_C: begin
            cmd.ld_c = SLOT_MEM;
            state_in = FWD_MUL;
         end
         FWD_MUL: begin
            cmd.mul_sel = MUL_REFLEX;
            state_in    = FWD_TEST;
         end
         FWD_TEST: begin
            if (stat.reflex) begin
               cmd.idx_op = IDX_NEXT;
               cmd.pos_op = POS_FWD_ERASE;
               phase_in   = PH_FWD;
               state_in   = ERASE;
            end else begin
               state_in = LAST;
            end
         end
         LAST: begin
            cmd.rd_sel = RD_PREV;
            state_in   = LAST_A;
         end
         LAST_A: begin
            cmd.ld_a   = SLOT_MEM;
            cmd.rd_sel = RD_NEXT;
            state_in   = LAST_C;
         end
         LAST_C: begin
            cmd.ld_c = SLOT_MEM;
            cmd.ld_b = SLOT_PT;
            state_in = LAST_MUL;
         end
         LAST_MUL: begin
            cmd.mul_sel = MUL_REFLEX;
            state_in    = LAST_TEST;
         end
         LAST_TEST: begin
            if (stat.reflex) begin
               cmd.idx_op = IDX_POS;
               phase_in   = PH_LAST;
               state_in   = ERASE;
            end else begin
               state_in = DONE;
            end
         end
         ERASE: begin
            if (stat.erase_more) begin
               cmd.rd_sel = RD_IDX_UP;
               state_in   = ERASE_WR;
            end else begin
               cmd.cnt_op = CNT_DEC;
               case (phase_ff)
                  PH_BACK: state_in = BACK;
                  PH_FWD:  state_in = FWD;
                  default: state_in = DONE;
               endcase
            end
         end
         ERASE_WR: begin
            cmd.wr_sel = WR_SHIFT;
            cmd.idx_op = IDX_INC;
            state_in   = ERASE;
         end
         DONE: begin
            state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         phase_ff <= PH_BACK;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign busy     = (state_ff != IDLE);
   assign done     = (state_ff == DONE);
   assign overflow = ovf_ff;

endmodule
`default_nettype wire

FILE: rtl/oach_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oach_datapath: hull table, index registers and exact geometry tests
// Holds the angle-sorted table memory, two multipliers and the compares.
// ----------------------------------------------------------------------------
module oach_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic signed [oach_pkg::COORD_BITS-1:0] point_x,
   input  wire logic signed [oach_pkg::COORD_BITS-1:0] point_y,
   input  wire logic signed [oach_pkg::CENTER_W-1:0]   center_x,
   input  wire logic signed [oach_pkg::CENTER_W-1:0]   center_y,
   input  wire oach_pkg::cmd_type                      cmd,
   output oach_pkg::stat_type                          stat,
   output logic [oach_pkg::CNT_W-1:0]                  count
);
   import oach_pkg::*;

   logic [ENTRY_W-1:0] mem [CAPACITY];
   logic [ENTRY_W-1:0] rdata_ff;

   logic signed [REL_W-1:0] px_ff, py_ff, ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic signed [REL_W-1:0] rx, ry;
   logic [CNT_W-1:0] pos_ff, pos_in, idx_ff, idx_in, cnt_ff, cnt_in;
   logic [CNT_W-1:0] prev_pos, prev2_pos, next_pos, next2_pos, rd_addr;
   logic signed [DIFF_W-1:0] m0a, m0b, m1a, m1b;
   logic signed [PROD_W-1:0] p0_ff, p1_ff;
   logic signed [PROD_W:0]   dn_ff, psum;
   logic signed [REL_W-1:0]  ntx, nty, npx, npy;
   logic                     half_t, half_p;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [ENTRY_W-1:0]       wr_data;

   function automatic logic [CNT_W-1:0] prev_of(input logic [CNT_W-1:0] i,
                                                input logic [CNT_W-1:0] n);
      prev_of = (i == '0) ? n - 1'b1 : i - 1'b1;
   endfunction

   function automatic logic [CNT_W-1:0] next_of(input logic [CNT_W-1:0] i,
                                                input logic [CNT_W-1:0] n);
      logic [CNT_W:0] s;
      s = {1'b0, i} + 1'b1;
      next_of = (s >= {1'b0, n}) ? '0 : s[CNT_W-1:0];
   endfunction

   function automatic logic upper(input logic signed [REL_W-1:0] x,
                                  input logic signed [REL_W-1:0] y);
      upper = (y > 0) || ((y == 0) && (x < 0));
   endfunction

   assign prev_pos  = prev_of(pos_ff, cnt_ff);
   assign prev2_pos = prev_of(prev_pos, cnt_ff);
   assign next_pos  = next_of(pos_ff, cnt_ff);
   assign next2_pos = next_of(next_pos, cnt_ff);

   // memory entry split
   assign rx = rdata_ff[REL_W-1:0];
   assign ry = rdata_ff[ENTRY_W-1:REL_W];

   always_comb begin
      case (cmd.rd_sel)
         RD_POS:    rd_addr = pos_ff;
         RD_PREV:   rd_addr = prev_pos;
         RD_PREV2:  rd_addr = prev2_pos;
         RD_NEXT:   rd_addr = next_pos;
         RD_NEXT2:  rd_addr = next2_pos;
         RD_IDX_DN: rd_addr = idx_ff - 1'b1;
         RD_IDX_UP: rd_addr = idx_ff + 1'b1;
         default:   rd_addr = pos_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff[IDX_W-1:0];
      wr_data = {py_ff, px_ff};
      case (cmd.wr_sel)
         WR_POINT: wr_en = 1'b1;
         WR_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[IDX_W-1:0];
            wr_data = rdata_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr[IDX_W-1:0]];
   end

   // zero vector takes the angle of the positive x axis
   always_comb begin
      ntx = bx_ff;
      nty = by_ff;
      npx = px_ff;
      npy = py_ff;
      if (bx_ff == 0 && by_ff == 0) ntx = REL_W'(1);
      if (px_ff == 0 && py_ff == 0) npx = REL_W'(1);
      half_t = upper(ntx, nty);
      half_p = upper(npx, npy);
   end

   always_comb begin
      case (cmd.mul_sel)
         MUL_ANGLE: begin
            m0a = DIFF_W'(ntx);
            m0b = DIFF_W'(npy);
            m1a = DIFF_W'(nty);
            m1b = DIFF_W'(npx);
         end
         MUL_DIST_PT: begin
            m0a = DIFF_W'(px_ff);
            m0b = DIFF_W'(px_ff);
            m1a = DIFF_W'(py_ff);
            m1b = DIFF_W'(py_ff);
         end
         MUL_DIST_TAB: begin
            m0a = DIFF_W'(bx_ff);
            m0b = DIFF_W'(bx_ff);
            m1a = DIFF_W'(by_ff);
            m1b = DIFF_W'(by_ff);
         end
         default: begin
            m0a = DIFF_W'(bx_ff) - DIFF_W'(ax_ff);
            m0b = DIFF_W'(cy_ff) - DIFF_W'(by_ff);
            m1a = DIFF_W'(cx_ff) - DIFF_W'(bx_ff);
            m1b = DIFF_W'(by_ff) - DIFF_W'(ay_ff);
         end
      endcase
   end

   assign psum = (PROD_W + 1)'(p0_ff) + (PROD_W + 1)'(p1_ff);

   always_ff @(posedge clock) begin
      p0_ff <= m0a * m0b;
      p1_ff <= m1a * m1b;
      if (cmd.save_dist) dn_ff <= psum;
      if (cmd.load_point) begin
         px_ff <= (REL_W'(point_x) <<< 1) - REL_W'(center_x);
         py_ff <= (REL_W'(point_y) <<< 1) - REL_W'(center_y);
      end
      case (cmd.ld_a)
         SLOT_MEM: begin ax_ff <= rx;    ay_ff <= ry;    end
         SLOT_PT:  begin ax_ff <= px_ff; ay_ff <= py_ff; end
         default:  begin ax_ff <= ax_ff; ay_ff <= ay_ff; end
      endcase
      case (cmd.ld_b)
         SLOT_MEM: begin bx_ff <= rx;    by_ff <= ry;    end
         SLOT_PT:  begin bx_ff <= px_ff; by_ff <= py_ff; end
         default:  begin bx_ff <= bx_ff; by_ff <= by_ff; end
      endcase
      case (cmd.ld_c)
         SLOT_MEM: begin cx_ff <= rx;    cy_ff <= ry;    end
         SLOT_PT:  begin cx_ff <= px_ff; cy_ff <= py_ff; end
         default:  begin cx_ff <= cx_ff; cy_ff <= cy_ff; end
      endcase
   end

   always_comb begin
      case (cmd.pos_op)
         POS_CLEAR:      pos_in = '0;
         POS_INC:        pos_in = pos_ff + 1'b1;
         POS_BACK_ERASE: pos_in = (pos_ff != '0) ? pos_ff - 1'b1 : pos_ff;
         POS_FWD_ERASE:  pos_in = (next_pos < pos_ff) ? pos_ff - 1'b1 : pos_ff;
         default:        pos_in = pos_ff;
      endcase
      case (cmd.idx_op)
         IDX_COUNT: idx_in = cnt_ff;
         IDX_PREV:  idx_in = prev_pos;
         IDX_NEXT:  idx_in = next_pos;
         IDX_POS:   idx_in = pos_ff;
         IDX_DEC:   idx_in = idx_ff - 1'b1;
         IDX_INC:   idx_in = idx_ff + 1'b1;
         default:   idx_in = idx_ff;
      endcase
      case (cmd.cnt_op)
         CNT_INC: cnt_in = cnt_ff + 1'b1;
         CNT_DEC: cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         pos_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
         idx_ff <= idx_in;
      end
   end

   always_comb begin
      stat.pos_end    = (pos_ff >= cnt_ff);
      stat.ang_less   = (!half_t && half_p) || ((half_t == half_p) && (p0_ff > p1_ff));
      stat.ang_eq     = (half_t == half_p) && (p0_ff == p1_ff);
      stat.farther    = (dn_ff > psum);
      stat.full       = (cnt_ff >= CNT_W'(CAPACITY));
      stat.small_hull = (cnt_ff <= CNT_W'(MIN_CLEANUP));
      stat.shift_more = (idx_ff > pos_ff);
      stat.erase_more = ({1'b0, idx_ff} + 1'b1 < {1'b0, cnt_ff});
      stat.reflex     = (p0_ff < p1_ff);
   end

   assign count = cnt_ff;

endmodule
`default_nettype wire
